// ----- hdl/arb_pkg.sv -----
// ----------------------------------------------------------------------------
// arb_pkg
// Shared types and constants of the retry backoff unit: channel payloads,
// command and register codes, reset values of the configuration registers.
// ----------------------------------------------------------------------------
package arb_pkg;

  // Command carried by each request beat
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_FAIL    = 2'd1,
    CMD_SUCCESS = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_DELAY      = 3'd0,
    CFG_MAX_DELAY      = 3'd1,
    CFG_BACKOFF_FACTOR = 3'd2,
    CFG_MAX_RETRIES    = 3'd3,
    CFG_RETRY_CLIENT   = 3'd4
  } cfg_idx_t;

  localparam int WIRE_TIME_BITS = 20;
  localparam int FACTOR_BITS    = 16;
  localparam int COUNT_BITS     = 9;
  localparam int STATUS_BITS    = 10;

  // Reset values of the configuration registers
  localparam logic [WIRE_TIME_BITS-1:0] MIN_DELAY_RST      = 20'd1000;
  localparam logic [WIRE_TIME_BITS-1:0] MAX_DELAY_RST      = 20'd60000;
  localparam logic [FACTOR_BITS-1:0]    BACKOFF_FACTOR_RST = 16'd512;
  localparam logic [7:0]                MAX_RETRIES_RST    = 8'd5;
  localparam logic                      RETRY_CLIENT_RST   = 1'b0;

  // Server error statuses: 499 and the 5xx range
  localparam logic [STATUS_BITS-1:0] STATUS_CLIENT_CLOSED = 10'd499;
  localparam logic [STATUS_BITS-1:0] STATUS_SERVER_LO     = 10'd500;
  localparam logic [STATUS_BITS-1:0] STATUS_SERVER_HI     = 10'd600;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    cmd_t                      cmd;
    logic [STATUS_BITS-1:0]    status;
    logic                      has_retry_after;
    logic [WIRE_TIME_BITS-1:0] retry_after_ticks;
  } req_t;

  typedef struct packed {
    logic                      retry_allowed;
    logic [WIRE_TIME_BITS-1:0] wait_ticks;
    logic [COUNT_BITS-1:0]     failure_count;
    logic                      retry_due;
  } rsp_t;

  typedef struct packed {
    cfg_idx_t                  index;
    logic [WIRE_TIME_BITS-1:0] data;
  } cfg_wr_t;

  // Register values handed from the register file to the core
  typedef struct packed {
    logic [WIRE_TIME_BITS-1:0] delay_floor;
    logic [WIRE_TIME_BITS-1:0] delay_ceiling;
    logic [FACTOR_BITS-1:0]    growth_factor;
    logic [7:0]                retry_limit;
    logic                      retry_on_client_error;
  } cfg_t;

endpackage

// ----- hdl/arb_stream_if.sv -----
// ----------------------------------------------------------------------------
// arb_stream_if
// Valid/ready channel with a typed payload; used for requests, responses
// and configuration writes.
// ----------------------------------------------------------------------------
interface arb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/arb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// arb_cfg_regs
// Configuration register file. Ready whenever out of reset; writes to unused
// indexes are dropped.
// ----------------------------------------------------------------------------
module arb_cfg_regs
  import arb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  arb_stream_if.sink   cfg,
  output cfg_t         regs
);

  assign cfg.ready = !rst;

  // Register write on each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.delay_floor           <= MIN_DELAY_RST;
      regs.delay_ceiling         <= MAX_DELAY_RST;
      regs.growth_factor         <= BACKOFF_FACTOR_RST;
      regs.retry_limit           <= MAX_RETRIES_RST;
      regs.retry_on_client_error <= RETRY_CLIENT_RST;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_MIN_DELAY:      regs.delay_floor           <= cfg.data.data;
        CFG_MAX_DELAY:      regs.delay_ceiling         <= cfg.data.data;
        CFG_BACKOFF_FACTOR: regs.growth_factor         <= cfg.data.data[FACTOR_BITS-1:0];
        CFG_MAX_RETRIES:    regs.retry_limit           <= cfg.data.data[7:0];
        CFG_RETRY_CLIENT:   regs.retry_on_client_error <= cfg.data.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/arb_core.sv -----
// ----------------------------------------------------------------------------
// arb_core
// Input register, single-pass state update (scale, clamp, countdown) and
// response register with stall handling.
// ----------------------------------------------------------------------------
module arb_core
  import arb_pkg::*;
#(
  parameter int TIME_BITS        = 20,
  parameter int FACTOR_FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         regs,
  arb_stream_if.sink   req,
  arb_stream_if.source rsp
);

  localparam int PROD_BITS = TIME_BITS + FACTOR_BITS;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [32:0] TIME_MAX_W = 33'(TIME_MAX);
  localparam logic [PROD_BITS-1:0] TIME_MAX_P = PROD_BITS'(TIME_MAX);

  // Clamp a wire-width time value into the internal time range
  function automatic logic [TIME_BITS-1:0] sat_time(input logic [WIRE_TIME_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > TIME_MAX_W) ? TIME_MAX : w[TIME_BITS-1:0];
  endfunction

  // Pipeline control
  logic s1_valid;
  req_t s1_data;
  logic o_valid;
  rsp_t o_data;
  logic advance;

  assign advance   = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !rst && (!s1_valid || !o_valid || rsp.ready);
  assign rsp.valid = o_valid;
  assign rsp.data  = o_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (req.valid && req.ready) s1_valid <= 1'b1;
      else if (advance)           s1_valid <= 1'b0;
      if (advance)        o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) s1_data <= req.data;
  end

  // Retry state
  logic [TIME_BITS-1:0]  current_delay, current_delay_next;
  logic [COUNT_BITS-1:0] retry_counter, retry_counter_next;
  logic                  may_retry, may_retry_next;
  logic [TIME_BITS-1:0]  countdown, countdown_next;

  // Scaled and clamped delay
  logic [PROD_BITS-1:0] prod, prod_shr;
  logic [TIME_BITS-1:0] scaled, lo, hi, clamped;
  logic                 server_err;

  always_comb begin
    prod     = PROD_BITS'(current_delay) * PROD_BITS'(regs.growth_factor);
    prod_shr = prod >> FACTOR_FRAC_BITS;
    scaled   = (prod_shr > TIME_MAX_P) ? TIME_MAX : prod_shr[TIME_BITS-1:0];
    lo       = sat_time(regs.delay_floor);
    hi       = sat_time(regs.delay_ceiling);
    clamped  = (scaled < lo) ? lo : scaled;
    if (clamped > hi) clamped = hi;
    server_err = (s1_data.status == STATUS_CLIENT_CLOSED) ||
                 ((s1_data.status >= STATUS_SERVER_LO) && (s1_data.status < STATUS_SERVER_HI));
  end

  // Next state per command
  logic [TIME_BITS-1:0] wait_val;
  always_comb begin
    current_delay_next = current_delay;
    retry_counter_next = retry_counter;
    may_retry_next     = may_retry;
    countdown_next     = countdown;
    wait_val           = '0;
    case (s1_data.cmd)
      CMD_TICK: begin
        if (countdown != '0) countdown_next = countdown - 1'b1;
      end
      CMD_FAIL: begin
        if (may_retry) begin
          if (retry_counter != '0) current_delay_next = clamped;
          wait_val = s1_data.has_retry_after ? sat_time(s1_data.retry_after_ticks)
                                             : current_delay_next;
          if (retry_counter >= COUNT_BITS'(regs.retry_limit)) may_retry_next = 1'b0;
          if (!regs.retry_on_client_error && !server_err) may_retry_next = 1'b0;
          if (may_retry_next) countdown_next = wait_val;
          if (retry_counter != COUNT_MAX) retry_counter_next = retry_counter + 1'b1;
        end
      end
      CMD_SUCCESS: begin
        current_delay_next = sat_time(regs.delay_floor);
        retry_counter_next = '0;
        may_retry_next     = 1'b1;
        countdown_next     = '0;
      end
      default: begin
      end
    endcase
  end

  // Response from the updated state
  rsp_t        rsp_next;
  logic        allowed;
  logic [32:0] wait_w;
  always_comb begin
    allowed = (retry_counter_next != '0) && may_retry_next;
    wait_w  = allowed ? 33'(countdown_next) : TIME_MAX_W;
    rsp_next.retry_allowed = allowed;
    rsp_next.wait_ticks    = wait_w[WIRE_TIME_BITS-1:0];
    rsp_next.failure_count = retry_counter_next;
    rsp_next.retry_due     = allowed && (countdown_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_delay <= sat_time(MIN_DELAY_RST);
      retry_counter <= '0;
      may_retry     <= 1'b1;
      countdown     <= '0;
    end else if (advance) begin
      current_delay <= current_delay_next;
      retry_counter <= retry_counter_next;
      may_retry     <= may_retry_next;
      countdown     <= countdown_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) o_data <= rsp_next;
  end

  // Checks
  a_due_needs_allowed: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (!o_data.retry_due || o_data.retry_allowed))
    else $error("retry_due without retry_allowed");

  a_blocked_fail_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_data.cmd == CMD_FAIL && !may_retry) |=> $stable(retry_counter))
    else $error("failure counted while retry blocked");

  a_success_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_data.cmd == CMD_SUCCESS) |=>
      (retry_counter == '0 && countdown == '0 && may_retry))
    else $error("success did not restore start state");

  a_tick_no_increase: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_data.cmd == CMD_TICK) |=> (countdown <= $past(countdown)))
    else $error("countdown rose on tick");

endmodule

// ----- hdl/adaptive_retry_backoff_unit.sv -----
// ----------------------------------------------------------------------------
// adaptive_retry_backoff_unit
// Retry controller with capped exponential backoff and countdown timer.
// ----------------------------------------------------------------------------
// Takes one request beat per clock while no response stalls (tick, failure,
// success or query) and returns one response beat for each, carrying the
// retry status after that request. Throughput is one request per cycle while
// no response stalls; each request passes the input register and the response
// register around the update logic, whose longest path is the TIME_BITS x 16
// delay multiply followed by the saturate and min/max clamp. A stalled response
// holds the pipeline; the input register still takes a new beat as soon as the
// response is taken. Configuration writes are accepted every cycle and should
// be issued only while no request is in flight.
module adaptive_retry_backoff_unit
  import arb_pkg::*;
#(
  parameter int TIME_BITS        = 20,
  parameter int FACTOR_FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  arb_stream_if.sink   cfg,
  arb_stream_if.sink   req,
  arb_stream_if.source rsp
);

  cfg_t regs;

  arb_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  arb_core #(
    .TIME_BITS        (TIME_BITS),
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .req  (req),
    .rsp  (rsp)
  );

endmodule
